// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with async active-low reset disable
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form: antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication form
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== design/fbte_pkg.sv =====
// types and constants of the fourteen-bit text encoder
// used by the queue, front, back and top modules; no dependencies
package fbte_pkg;

  localparam logic [15:0] UnitBase   = 16'h4E00;
  localparam logic [15:0] MarkBase   = 16'h3D00;
  localparam logic [2:0]  GroupBytes = 3'd7;
  localparam int          QueueDepth = 2;

  // one group of work handed from the front to the back
  typedef struct packed {
    logic [55:0] group;      // 56 bits, oldest byte in the top bits, zero padded
    logic        four_units; // 1: four code units, 0: two
    logic        mark;       // a marker unit follows the code units
    logic        last;       // group closes the stream
    logic [2:0]  cnt;        // bytes in the group
  } job_t;

endpackage

// ===== design/fbte_queue.sv =====
// small queue of jobs between the front and the back
// depends on fbte_pkg
module fbte_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fbte_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output fbte_pkg::job_t pop_job_o
);
  import fbte_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/fbte_front.sv =====
// front of the encoder: gathers bytes into 56-bit groups and queues jobs
// depends on fbte_pkg
module fbte_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_byte_i,
  input  logic           in_eos_i,
  input  logic           q_full_i,
  output logic           push_o,
  output fbte_pkg::job_t job_o
);
  import fbte_pkg::*;

  logic [47:0] held_q, held_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [2:0]  cnt_next;
  logic [55:0] acc;
  logic [55:0] padded;
  logic        accept;
  logic        full_group;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign cnt_next   = cnt_q + 3'd1;
  assign acc        = {held_q, in_byte_i};
  assign full_group = (cnt_next == GroupBytes);
  assign push_o     = accept && (full_group || in_eos_i);

  // left-align the leftover bytes, zero fill below
  always_comb begin
    case (cnt_next)
      3'd1:    padded = {acc[7:0],  48'd0};
      3'd2:    padded = {acc[15:0], 40'd0};
      3'd3:    padded = {acc[23:0], 32'd0};
      3'd4:    padded = {acc[31:0], 24'd0};
      3'd5:    padded = {acc[39:0], 16'd0};
      3'd6:    padded = {acc[47:0], 8'd0};
      default: padded = acc;
    endcase
  end

  always_comb begin
    job_o.group      = full_group ? acc : padded;
    job_o.four_units = (cnt_next >= 3'd4);
    job_o.mark       = !full_group;
    job_o.last       = in_eos_i;
    job_o.cnt        = cnt_next;
  end

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (push_o) begin
        held_d = '0;
        cnt_d  = '0;
      end else begin
        held_d = acc[47:0];
        cnt_d  = cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== design/fbte_back.sv =====
// back of the encoder: turns queued jobs into code units, one per cycle unless the receiver stalls
// depends on fbte_pkg
module fbte_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  fbte_pkg::job_t q_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    out_unit_o,
  output logic           out_last_o
);
  import fbte_pkg::*;

  job_t        job_q;
  logic        job_vld_q, job_vld_d;
  logic [2:0]  idx_q, idx_d;
  logic        out_vld_q, out_vld_d;
  logic [15:0] out_unit_q;
  logic        out_last_q;

  logic [2:0]  nunits;
  logic        is_val;
  logic [13:0] val;
  logic [15:0] unit;
  logic        final_unit;
  logic        unit_last;
  logic        out_free;
  logic        advance;

  assign nunits   = job_q.four_units ? 3'd4 : 3'd2;
  assign is_val   = (idx_q < nunits);
  assign out_free = !out_vld_q || out_ready_i;
  assign advance  = job_vld_q && out_free;

  // 14-bit slices, most significant first
  always_comb begin
    case (idx_q[1:0])
      2'd0:    val = job_q.group[55:42];
      2'd1:    val = job_q.group[41:28];
      2'd2:    val = job_q.group[27:14];
      default: val = job_q.group[13:0];
    endcase
  end

  always_comb begin
    if (is_val) begin
      unit       = UnitBase + {2'b00, val};
      final_unit = (idx_q == nunits - 3'd1) && !job_q.mark;
      unit_last  = final_unit && job_q.last;
    end else begin
      unit       = MarkBase + {13'd0, job_q.cnt};
      final_unit = 1'b1;
      unit_last  = 1'b1;
    end
  end

  assign pop_o = q_valid_i && (!job_vld_q || (advance && final_unit));

  always_comb begin
    job_vld_d = job_vld_q;
    idx_d     = idx_q;
    if (pop_o) begin
      job_vld_d = 1'b1;
      idx_d     = '0;
    end else if (advance) begin
      if (final_unit) begin
        job_vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
    if (advance) begin
      out_unit_q <= unit;
      out_last_q <= unit_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_unit_o  = out_unit_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== design/fourteen_bit_text_encoder.sv =====
// fourteen-bit text encoder: byte stream in, 16-bit code units out
// depends on fbte_pkg, fbte_front, fbte_queue and fbte_back
//
// usage:
//   s_axis carries one byte per item, tlast marks the final byte of a stream.
//   m_axis carries one 16-bit code unit per item, tlast marks the stream's
//   final unit. every seventh byte yields four units 0x4E00 + 14-bit slice;
//   a stream ending with 1..6 leftover bytes yields two (1..3) or four (4..6)
//   padded units and then the marker 0x3D00 + leftover count.
//   the first unit of a group passes the job queue, the job register and
//   the output register; further units follow one per cycle unless stalled.
//   throughput: one byte per cycle when each stream runs past a few groups
//   and the receiver does not stall; the back end emits one unit per cycle,
//   so a job of up to five units keeps the back end busy while they drain
//   and short streams may fill the two-entry job queue and stall the input.
//   reset clears the held bytes, the queue count and the output valid flag.
//   when the receiver stalls the output unit holds; the queue fills and
//   then s_axis_tready_o drops until units drain.
module fourteen_bit_text_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] code_unit
  output logic        m_axis_tlast_o    // last_unit
);
  import fbte_pkg::*;

  job_t push_job;
  job_t pop_job;
  logic push;
  logic full;
  logic q_valid;
  logic pop;

  fbte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_eos_i   (s_axis_tlast_i),
    .q_full_i   (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  fbte_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  fbte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_unit_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== design/fbte_checker.sv =====
// port-level checks of the fourteen-bit text encoder, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module fbte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // a stalled unit stays offered
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "output valid dropped under stall")

  // a stalled unit keeps its payload
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output payload changed under stall")

  // every unit is a code unit or a marker with count 1..6
  `ASSERT_IMP(a_unit_range, clk_i, rst_ni, m_axis_tvalid_o, (m_axis_tdata_o >= 16'h4E00 && m_axis_tdata_o <= 16'h8DFF) || (m_axis_tdata_o >= 16'h3D01 && m_axis_tdata_o <= 16'h3D06), "unit out of range")

  // a marker always closes the stream
  `ASSERT_IMP(a_mark_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[15:8] == 8'h3D, m_axis_tlast_o, "marker without last")

endmodule

bind fourteen_bit_text_encoder fbte_checker u_fbte_checker (.*);
